// ----- rtl/spq_pkg.sv -----
`default_nettype none

package spq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int ID_WIDTH_DEFAULT   = 16;
   localparam int PRIO_WIDTH_DEFAULT = 16;

   localparam int KIND_WIDTH  = 3;
   localparam int FIELD_WIDTH = 16;
   localparam int POS_WIDTH   = 4;
   localparam int SIZE_WIDTH  = 5;
   localparam int PEEK_DEPTH  = 2 ** POS_WIDTH;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_INSERT   = 3'd0,
      KIND_POP      = 3'd1,
      KIND_REMOVE   = 3'd2,
      KIND_CHANGE   = 3'd3,
      KIND_CONTAINS = 3'd4,
      KIND_READ     = 3'd5,
      KIND_CLEAR    = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REINSERT,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_POP
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      logic         match_prio;
   } cell_ctrl_type;

   typedef struct packed {
      logic ge;
      logic seen;
   } link_type;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]  kind;
      logic [FIELD_WIDTH-1:0] element_id;
      logic [FIELD_WIDTH-1:0] priority_req;
      logic [FIELD_WIDTH-1:0] target_priority;
      logic [POS_WIDTH-1:0]   position;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]             status;
      logic                   found;
      logic [SIZE_WIDTH-1:0]  size;
      logic [FIELD_WIDTH-1:0] head_element;
      logic [FIELD_WIDTH-1:0] head_priority;
      logic [FIELD_WIDTH-1:0] read_element;
      logic [FIELD_WIDTH-1:0] read_priority;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ----- rtl/spq_chan_if.sv -----
`default_nettype none

interface spq_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/sorted_priority_queue_top.sv -----
// channel   dir  handshake      payload
// req_if    in   valid/ready    kind, element_id, priority_req, target_priority, position
// rsp_if    out  valid/ready    status, found, size, head/read element and priority
//
// one operation in flight; a transfer is taken in idle or finish, worked on in the
// cell row in exec, and its result registered in finish once the output register is
// free; change priority adds a reinsert pass between exec and finish
// the next request is taken in the same cycle the result is loaded into the output
// register; a stalled output holds the queue until it drains
// reset clears the entry count and control state only; cell contents need no reset

`default_nettype none

module sorted_priority_queue_top #(
   parameter int DEPTH      = spq_pkg::DEPTH_DEFAULT,
   parameter int ID_WIDTH   = spq_pkg::ID_WIDTH_DEFAULT,
   parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEFAULT
) (
   input wire logic   clock,
   input wire logic   reset,
   spq_chan_if.sink   req_if,
   spq_chan_if.source rsp_if
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int PEEK  = spq_pkg::PEEK_DEPTH;

   spq_pkg::cell_ctrl_type   cell_ctrl;
   spq_pkg::link_type        link [DEPTH + 1];
   logic [ID_WIDTH-1:0]      cell_id [DEPTH];
   logic [PRIO_WIDTH-1:0]    cell_prio [DEPTH];
   logic [ID_WIDTH-1:0]      peek_id [PEEK];
   logic [PRIO_WIDTH-1:0]    peek_prio [PEEK];
   logic [ID_WIDTH-1:0]      key_id;
   logic [PRIO_WIDTH-1:0]    key_prio;
   logic [CNT_W-1:0]         count;
   spq_pkg::req_payload_type req_payload;
   spq_pkg::rsp_payload_type rsp_payload;
   logic                     req_ready;
   logic                     rsp_valid;

   assign req_payload   = req_if.payload;
   assign req_if.ready  = req_ready;
   assign rsp_if.valid  = rsp_valid;
   assign rsp_if.payload = rsp_payload;

   assign link[0].ge   = 1'b1;
   assign link[0].seen = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ID_WIDTH-1:0]   left_id;
      logic [PRIO_WIDTH-1:0] left_prio;
      logic [ID_WIDTH-1:0]   right_id;
      logic [PRIO_WIDTH-1:0] right_prio;

      if (i == 0) begin : g_first
         assign left_id   = key_id;
         assign left_prio = key_prio;
      end else begin : g_mid
         assign left_id   = cell_id[i-1];
         assign left_prio = cell_prio[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_id   = cell_id[i];
         assign right_prio = cell_prio[i];
      end else begin : g_inner
         assign right_id   = cell_id[i+1];
         assign right_prio = cell_prio[i+1];
      end

      spq_cell #(
         .ID_WIDTH   (ID_WIDTH),
         .PRIO_WIDTH (PRIO_WIDTH)
      ) u_cell (
         .clock      (clock),
         .occ        (CNT_W'(i) < count),
         .ctrl       (cell_ctrl),
         .key_id     (key_id),
         .key_prio   (key_prio),
         .left_id    (left_id),
         .left_prio  (left_prio),
         .right_id   (right_id),
         .right_prio (right_prio),
         .link_in    (link[i]),
         .link_out   (link[i+1]),
         .id_out     (cell_id[i]),
         .prio_out   (cell_prio[i])
      );
   end

   for (genvar k = 0; k < PEEK; k++) begin : g_peek
      if (k < DEPTH) begin : g_used
         assign peek_id[k]   = cell_id[k];
         assign peek_prio[k] = cell_prio[k];
      end else begin : g_unused
         assign peek_id[k]   = '0;
         assign peek_prio[k] = '0;
      end
   end

   spq_ctrl #(
      .DEPTH      (DEPTH),
      .ID_WIDTH   (ID_WIDTH),
      .PRIO_WIDTH (PRIO_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_payload (req_payload),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_ready   (rsp_if.ready),
      .seen_last   (link[DEPTH].seen),
      .head_id     (cell_id[0]),
      .head_prio   (cell_prio[0]),
      .peek_id     (peek_id),
      .peek_prio   (peek_prio),
      .cell_ctrl   (cell_ctrl),
      .key_id      (key_id),
      .key_prio    (key_prio),
      .count       (count)
   );

endmodule

`default_nettype wire

// ----- rtl/spq_cell.sv -----
`default_nettype none

module spq_cell #(
   parameter int ID_WIDTH   = spq_pkg::ID_WIDTH_DEFAULT,
   parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  occ,
   input  wire spq_pkg::cell_ctrl_type ctrl,
   input  wire logic [ID_WIDTH-1:0]   key_id,
   input  wire logic [PRIO_WIDTH-1:0] key_prio,
   input  wire logic [ID_WIDTH-1:0]   left_id,
   input  wire logic [PRIO_WIDTH-1:0] left_prio,
   input  wire logic [ID_WIDTH-1:0]   right_id,
   input  wire logic [PRIO_WIDTH-1:0] right_prio,
   input  wire spq_pkg::link_type     link_in,
   output spq_pkg::link_type          link_out,
   output logic      [ID_WIDTH-1:0]   id_out,
   output logic      [PRIO_WIDTH-1:0] prio_out
);

   logic [ID_WIDTH-1:0]   id_ff, id_in;
   logic [PRIO_WIDTH-1:0] prio_ff, prio_in;
   logic                  ge_self;
   logic                  match_self;

   assign ge_self    = occ && (prio_ff >= key_prio);
   assign match_self = occ && (id_ff == key_id) && (!ctrl.match_prio || (prio_ff == key_prio));

   assign link_out.ge   = ge_self;
   assign link_out.seen = link_in.seen | match_self;

   always_comb begin
      id_in   = id_ff;
      prio_in = prio_ff;
      case (ctrl.cmd)
         spq_pkg::CELL_INSERT: begin
            if (!ge_self) begin
               if (link_in.ge) begin
                  id_in   = key_id;
                  prio_in = key_prio;
               end else begin
                  id_in   = left_id;
                  prio_in = left_prio;
               end
            end
         end
         spq_pkg::CELL_REMOVE: begin
            if (link_out.seen) begin
               id_in   = right_id;
               prio_in = right_prio;
            end
         end
         spq_pkg::CELL_POP: begin
            id_in   = right_id;
            prio_in = right_prio;
         end
         default: begin
            id_in   = id_ff;
            prio_in = prio_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      prio_ff <= prio_in;
   end

   assign id_out   = id_ff;
   assign prio_out = prio_ff;

endmodule

`default_nettype wire

// ----- rtl/spq_ctrl.sv -----
`default_nettype none

module spq_ctrl #(
   parameter int DEPTH      = spq_pkg::DEPTH_DEFAULT,
   parameter int ID_WIDTH   = spq_pkg::ID_WIDTH_DEFAULT,
   parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEFAULT,
   localparam int CNT_W     = $clog2(DEPTH + 1)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire spq_pkg::req_payload_type req_payload,
   output logic                          req_ready,
   output logic                          rsp_valid,
   output spq_pkg::rsp_payload_type      rsp_payload,
   input  wire logic                     rsp_ready,
   input  wire logic                     seen_last,
   input  wire logic [ID_WIDTH-1:0]      head_id,
   input  wire logic [PRIO_WIDTH-1:0]    head_prio,
   input  wire logic [ID_WIDTH-1:0]      peek_id [spq_pkg::PEEK_DEPTH],
   input  wire logic [PRIO_WIDTH-1:0]    peek_prio [spq_pkg::PEEK_DEPTH],
   output spq_pkg::cell_ctrl_type        cell_ctrl,
   output logic      [ID_WIDTH-1:0]      key_id,
   output logic      [PRIO_WIDTH-1:0]    key_prio,
   output logic      [CNT_W-1:0]         count
);

   localparam int FW    = spq_pkg::FIELD_WIDTH;
   localparam int SW    = spq_pkg::SIZE_WIDTH;
   localparam int PW    = spq_pkg::POS_WIDTH;
   localparam int CMP_W = (CNT_W > PW) ? CNT_W : PW;

   spq_pkg::state_type       state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   spq_pkg::req_payload_type op_ff, op_in;
   spq_pkg::status_type      status_ff, status_in;
   logic                     found_ff, found_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   spq_pkg::rsp_payload_type rsp_ff, rsp_in;
   logic                     out_free;
   logic                     empty;
   logic                     read_ok;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign empty    = (count_ff == '0);
   assign read_ok  = (op_ff.kind == spq_pkg::KIND_READ) && (status_ff == spq_pkg::STAT_OK);

   assign key_id   = ID_WIDTH'(op_ff.element_id);
   assign key_prio = (state_ff == spq_pkg::ST_REINSERT) ? PRIO_WIDTH'(op_ff.target_priority)
                                                        : PRIO_WIDTH'(op_ff.priority_req);

   always_comb begin
      state_in             = state_ff;
      count_in             = count_ff;
      op_in                = op_ff;
      status_in            = status_ff;
      found_in             = found_ff;
      rsp_valid_in         = rsp_valid_ff && !rsp_ready;
      rsp_in               = rsp_ff;
      req_ready            = 1'b0;
      cell_ctrl.cmd        = spq_pkg::CELL_HOLD;
      cell_ctrl.match_prio = 1'b0;
      case (state_ff)
         spq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_payload;
               state_in = spq_pkg::ST_EXEC;
            end
         end
         spq_pkg::ST_EXEC: begin
            status_in = spq_pkg::STAT_OK;
            found_in  = 1'b0;
            state_in  = spq_pkg::ST_FINISH;
            case (op_ff.kind)
               spq_pkg::KIND_INSERT: begin
                  if (count_ff == CNT_W'(DEPTH)) begin
                     status_in = spq_pkg::STAT_FULL;
                  end else begin
                     cell_ctrl.cmd = spq_pkg::CELL_INSERT;
                     count_in      = count_ff + 1'b1;
                  end
               end
               spq_pkg::KIND_POP: begin
                  if (empty) begin
                     status_in = spq_pkg::STAT_EMPTY;
                  end else begin
                     cell_ctrl.cmd = spq_pkg::CELL_POP;
                     count_in      = count_ff - 1'b1;
                  end
               end
               spq_pkg::KIND_REMOVE: begin
                  if (empty) begin
                     status_in = spq_pkg::STAT_EMPTY;
                  end else begin
                     cell_ctrl.cmd = spq_pkg::CELL_REMOVE;
                     if (seen_last) begin
                        count_in = count_ff - 1'b1;
                     end else begin
                        status_in = spq_pkg::STAT_NOT_FOUND;
                     end
                  end
               end
               spq_pkg::KIND_CHANGE: begin
                  if (empty) begin
                     status_in = spq_pkg::STAT_EMPTY;
                  end else begin
                     cell_ctrl.cmd        = spq_pkg::CELL_REMOVE;
                     cell_ctrl.match_prio = 1'b1;
                     if (seen_last) begin
                        count_in = count_ff - 1'b1;
                        state_in = spq_pkg::ST_REINSERT;
                     end else begin
                        status_in = spq_pkg::STAT_NOT_FOUND;
                     end
                  end
               end
               spq_pkg::KIND_CONTAINS: begin
                  found_in = seen_last;
               end
               spq_pkg::KIND_READ: begin
                  if (empty) begin
                     status_in = spq_pkg::STAT_EMPTY;
                  end else if (CMP_W'(op_ff.position) >= CMP_W'(count_ff)) begin
                     status_in = spq_pkg::STAT_NOT_FOUND;
                  end
               end
               spq_pkg::KIND_CLEAR: begin
                  count_in = '0;
               end
               default: begin
                  status_in = spq_pkg::STAT_OK;
               end
            endcase
         end
         spq_pkg::ST_REINSERT: begin
            cell_ctrl.cmd = spq_pkg::CELL_INSERT;
            count_in      = count_ff + 1'b1;
            state_in      = spq_pkg::ST_FINISH;
         end
         spq_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = status_ff;
               rsp_in.found         = found_ff;
               rsp_in.size          = SW'(count_ff);
               rsp_in.head_element  = empty ? '0 : FW'(head_id);
               rsp_in.head_priority = empty ? '0 : FW'(head_prio);
               rsp_in.read_element  = read_ok ? FW'(peek_id[op_ff.position]) : '0;
               rsp_in.read_priority = read_ok ? FW'(peek_prio[op_ff.position]) : '0;
               req_ready            = 1'b1;
               if (req_valid) begin
                  op_in    = req_payload;
                  state_in = spq_pkg::ST_EXEC;
               end else begin
                  state_in = spq_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = spq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spq_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign count       = count_ff;

endmodule

`default_nettype wire
